@@ rtl/hhfl_pkg.sv @@
// Shared types, codes and helpers for the HTTP header field locator.
// No dependencies; used by every module of the block and by the port checker.
package hhfl_pkg;

  // Control characters tracked by the blank-line detector, and the letter range and offset for case folding
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Blank-line counter: CR LF CR LF reaches this state
  localparam logic [2:0] BLANK_DONE = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_PATTERN_BYTES  = 2'd0;
  localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd1;
  localparam logic [1:0] CFG_TERMINATOR     = 2'd2;

  // Register reset values
  localparam logic [3:0] PATTERN_LENGTH_RESET = 4'd6;
  localparam logic [7:0] TERMINATOR_RESET     = 8'd13;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_NONE    = 2'd0,
    STATUS_MATCH   = 2'd1,
    STATUS_PARTIAL = 2'd2
  } status_t;

  // Per-packet search phase
  typedef enum logic [1:0] {
    PHASE_SEARCH = 2'd0,
    PHASE_COUNT  = 2'd1,
    PHASE_DONE   = 2'd2
  } phase_t;

  // Result word layout on the master side
  localparam int OUT_TDATA_W = 40;

  // ASCII letters folded to lower case
  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

@@ rtl/hhfl_blank_detect.sv @@
// Tracks the CR LF CR LF blank line that ends the HTTP header.
// Depends on hhfl_pkg for the character and state constants.
module hhfl_blank_detect #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,      // a byte is processed this cycle
  input  logic                  clear,     // packet ends with this byte
  input  logic [7:0]            data_byte,
  input  logic [COUNT_BITS-1:0] position,  // offset of this byte
  output logic                  seen_next,
  output logic [COUNT_BITS-1:0] end_pos_next
);

  logic [2:0]            blank_state;
  logic [2:0]            blank_state_next;
  logic                  seen;
  logic [COUNT_BITS-1:0] end_pos;
  logic [2:0]            stepped;

  // Counter steps on CR at even states, LF at odd states, else restarts
  always_comb begin
    stepped = 3'd0;
    if (data_byte == hhfl_pkg::CHAR_CR) begin
      stepped = blank_state[0] ? 3'd0 : blank_state + 3'd1;
    end else if (data_byte == hhfl_pkg::CHAR_LF) begin
      stepped = blank_state[0] ? blank_state + 3'd1 : 3'd0;
    end
    blank_state_next = blank_state;
    seen_next        = seen;
    end_pos_next     = end_pos;
    if (!seen) begin
      blank_state_next = stepped;
      if (stepped >= hhfl_pkg::BLANK_DONE) begin
        blank_state_next = hhfl_pkg::BLANK_DONE;
        seen_next        = 1'b1;
        end_pos_next     = position;
      end
    end
  end

  // State holds once the header end is found; cleared per packet
  always_ff @(posedge clk) begin
    if (rst || (step && clear)) begin
      blank_state <= '0;
      seen        <= 1'b0;
      end_pos     <= '0;
    end else if (step) begin
      blank_state <= blank_state_next;
      seen        <= seen_next;
      end_pos     <= end_pos_next;
    end
  end

endmodule

@@ rtl/hhfl_match.sv @@
// Window compare against the configured pattern: exact match and case-folded prefix.
// Depends on hhfl_pkg for the case-folding helper.
module hhfl_match #(
  parameter int MAX_PATTERN_BYTES = 8
) (
  input  logic [MAX_PATTERN_BYTES*8-1:0] window,      // newest byte in bits 7..0
  input  logic [63:0]                    pattern,     // first byte in bits 7..0
  input  logic [3:0]                     exact_len,
  input  logic [3:0]                     fold_len,
  output logic                           exact_eq,
  output logic                           fold_eq
);

  localparam int AW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  logic [7:0] win_b [MAX_PATTERN_BYTES];
  logic [7:0] pat_b [MAX_PATTERN_BYTES];

  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_split
    assign win_b[i] = window[i*8 +: 8];
    assign pat_b[i] = pattern[i*8 +: 8];
  end

  // Pattern byte p lines up with the window byte of age len-1-p
  always_comb begin
    logic [3:0] age_x;
    logic [3:0] age_f;
    exact_eq = 1'b1;
    fold_eq  = 1'b1;
    for (int p = 0; p < MAX_PATTERN_BYTES; p++) begin
      age_x = exact_len - 4'd1 - 4'(p);
      age_f = fold_len - 4'd1 - 4'(p);
      if (4'(p) < exact_len && win_b[age_x[AW-1:0]] != pat_b[p]) begin
        exact_eq = 1'b0;
      end
      if (4'(p) < fold_len &&
          hhfl_pkg::fold_lower(win_b[age_f[AW-1:0]]) != hhfl_pkg::fold_lower(pat_b[p])) begin
        fold_eq = 1'b0;
      end
    end
  end

endmodule

@@ rtl/http_header_field_locator_unit.sv @@
// HTTP header field locator: finds a configured pattern in the header of a packet
// and reports the value offset and length at the last byte of the packet.
// Each byte is registered on entry and then processed from the input register; the result
// of the last byte is loaded into the output register when that byte is processed.
// One byte per cycle via the combinational compare; a last byte waits on a blocked result.
// Reset (rst, synchronous) empties both registers and restores register defaults.
module http_header_field_locator_unit #(
  parameter int MAX_PATTERN_BYTES = 8,
  parameter int COUNT_BITS        = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] data_byte
  input  logic        s_tlast,     // last_byte
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,     // [1:0] status, [17:2] value_offset, [33:18] value_length
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int         WIN_W   = MAX_PATTERN_BYTES * 8;
  localparam logic [3:0] MAX_LEN = 4'(MAX_PATTERN_BYTES);

  // Configuration registers
  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [7:0]  terminator;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Packet state
  logic [WIN_W-1:0]      window;
  logic [COUNT_BITS-1:0] byte_count;
  hhfl_pkg::phase_t      phase;
  logic [COUNT_BITS-1:0] found_offset;
  logic [COUNT_BITS-1:0] found_length;

  // Next values
  logic [WIN_W-1:0]      window_next;
  logic [COUNT_BITS-1:0] byte_count_next;
  hhfl_pkg::phase_t      phase_next;
  logic [COUNT_BITS-1:0] found_offset_next;
  logic [COUNT_BITS-1:0] found_length_next;

  logic                  advance;
  logic [3:0]            plen;
  logic                  hdr_seen;
  logic [COUNT_BITS-1:0] hdr_pos;
  logic                  exact_eq;
  logic                  fold_eq;
  logic                  short_pkt;
  logic [COUNT_BITS-1:0] start;
  hhfl_pkg::status_t     status_next;
  logic [15:0]           offset_out;
  logic [15:0]           length_out;

  // A byte moves on unless it is a last byte and the result register is blocked
  assign advance   = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= hhfl_pkg::PATTERN_LENGTH_RESET;
      terminator     <= hhfl_pkg::TERMINATOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hhfl_pkg::CFG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        hhfl_pkg::CFG_PATTERN_LENGTH: pattern_length <= cfg_data[3:0];
        hhfl_pkg::CFG_TERMINATOR:     terminator     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Effective pattern length, clamped to 1..MAX
  always_comb begin
    plen = pattern_length;
    if (pattern_length == 4'd0) begin
      plen = 4'd1;
    end else if (pattern_length > MAX_LEN) begin
      plen = MAX_LEN;
    end
  end

  // Window shift and saturating byte count
  assign window_next     = WIN_W'({window, in_byte});
  assign byte_count_next = (&byte_count) ? byte_count : byte_count + 1'b1;
  assign short_pkt       = byte_count_next <= COUNT_BITS'(plen);
  assign start           = byte_count_next - COUNT_BITS'(plen);

  hhfl_blank_detect #(
    .COUNT_BITS(COUNT_BITS)
  ) u_blank (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .clear       (in_last),
    .data_byte   (in_byte),
    .position    (byte_count),
    .seen_next   (hdr_seen),
    .end_pos_next(hdr_pos)
  );

  hhfl_match #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_match (
    .window   (window_next),
    .pattern  (pattern_bytes),
    .exact_len(plen),
    .fold_len (byte_count_next[3:0]),
    .exact_eq (exact_eq),
    .fold_eq  (fold_eq)
  );

  // Search and value-count phases
  always_comb begin
    phase_next        = phase;
    found_offset_next = found_offset;
    found_length_next = found_length;
    case (phase)
      hhfl_pkg::PHASE_COUNT: begin
        if (in_byte == terminator) begin
          phase_next = hhfl_pkg::PHASE_DONE;
        end else if (!(&found_length)) begin
          found_length_next = found_length + 1'b1;
        end
      end
      hhfl_pkg::PHASE_SEARCH: begin
        if (byte_count_next >= COUNT_BITS'(plen) && exact_eq &&
            (!hdr_seen || start < hdr_pos)) begin
          phase_next        = hhfl_pkg::PHASE_COUNT;
          found_offset_next = byte_count_next;
          found_length_next = '0;
        end
      end
      default: ;
    endcase
  end

  // Result at the last byte
  always_comb begin
    status_next = hhfl_pkg::STATUS_NONE;
    offset_out  = '0;
    length_out  = '0;
    if (short_pkt) begin
      status_next = fold_eq ? hhfl_pkg::STATUS_PARTIAL : hhfl_pkg::STATUS_NONE;
    end else begin
      case (phase_next)
        hhfl_pkg::PHASE_COUNT: begin
          status_next = hhfl_pkg::STATUS_PARTIAL;
          offset_out  = 16'(found_offset_next);
        end
        hhfl_pkg::PHASE_DONE: begin
          status_next = hhfl_pkg::STATUS_MATCH;
          offset_out  = 16'(found_offset_next);
          length_out  = 16'(found_length_next);
        end
        default: ;
      endcase
    end
  end

  // Packet state update; the last byte returns it to reset values
  always_ff @(posedge clk) begin
    if (rst || (advance && in_last)) begin
      window       <= '0;
      byte_count   <= '0;
      phase        <= hhfl_pkg::PHASE_SEARCH;
      found_offset <= '0;
      found_length <= '0;
    end else if (advance) begin
      window       <= window_next;
      byte_count   <= byte_count_next;
      phase        <= phase_next;
      found_offset <= found_offset_next;
      found_length <= found_length_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      m_tdata <= {6'd0, length_out, offset_out, status_next};
    end
  end

endmodule

@@ rtl/hhfl_checker.sv @@
// Port-level checks for the HTTP header field locator, bound to the top level.
// Depends on hhfl_pkg for the status codes.
module hhfl_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // A blocked result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // Status is one of the defined codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("undefined status code");

  // No match carries no offset or length
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == hhfl_pkg::STATUS_NONE |-> m_tdata[33:2] == 32'd0)
    else $error("no-match result with nonzero fields");

  // Partial match carries no length
  a_partial: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == hhfl_pkg::STATUS_PARTIAL |-> m_tdata[33:18] == 16'd0)
    else $error("partial result with nonzero length");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind http_header_field_locator_unit hhfl_checker u_hhfl_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

@@ tb/http_header_field_locator_unit_tb.sv @@
// Testbench for http_header_field_locator_unit: streams packets of header bytes,
// predicts every result word with its own model of the field search and checks it.
// Depends on hhfl_pkg (codes, register indexes, reset values) and the block's RTL.
`timescale 1ns / 1ps

module http_header_field_locator_unit_tb;

  localparam int CNT_MAX        = 65535;
  localparam int RANDOM_BYTES   = 720;
  localparam int PHASE_BYTES    = 60;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  // index with no register behind it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    hhfl_pkg::status_t status;
    logic [15:0]       offset;
    logic [15:0]       length;
  } field_result_t;

  // Field search predictor and queue of result words still due
  class locator_scoreboard;
    logic [63:0]      pattern;
    logic [3:0]       pat_len;
    logic [7:0]       term;
    logic [63:0]      window;
    int unsigned      count;
    logic [2:0]       blank;
    bit               hdr_seen;
    int unsigned      hdr_pos;
    hhfl_pkg::phase_t phase;
    int unsigned      found_off;
    int unsigned      found_len;
    field_result_t    results_due[$];
    int               errors;

    function new();
      pattern = '0;
      pat_len = hhfl_pkg::PATTERN_LENGTH_RESET;
      term    = hhfl_pkg::TERMINATOR_RESET;
      errors  = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      window    = '0;
      count     = 0;
      blank     = '0;
      hdr_seen  = 0;
      hdr_pos   = 0;
      phase     = hhfl_pkg::PHASE_SEARCH;
      found_off = 0;
      found_len = 0;
    endfunction

    function logic [7:0] to_lower(logic [7:0] c);
      return (c >= hhfl_pkg::CHAR_UPPER_A && c <= hhfl_pkg::CHAR_UPPER_Z) ?
             c + hhfl_pkg::CASE_OFFSET : c;
    endfunction

    function void note_config(logic [1:0] idx, logic [63:0] data);
      case (idx)
        hhfl_pkg::CFG_PATTERN_BYTES:  pattern = data;
        hhfl_pkg::CFG_PATTERN_LENGTH: pat_len = data[3:0];
        hhfl_pkg::CFG_TERMINATOR:     term    = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, bit last);
      int unsigned   plen, pos, n, p;
      bit            eq;
      field_result_t res;
      plen = (pat_len == 0) ? 1 : (pat_len > 8) ? 8 : pat_len;
      pos  = count;
      n    = (count < CNT_MAX) ? count + 1 : CNT_MAX;
      window = {window[55:0], b};
      count  = n;

      // CR LF CR LF tracker, frozen once the header end is found
      if (!hdr_seen) begin
        if (b == hhfl_pkg::CHAR_CR) blank = blank[0] ? 3'd0 : blank + 3'd1;
        else if (b == hhfl_pkg::CHAR_LF) blank = blank[0] ? blank + 3'd1 : 3'd0;
        else blank = 3'd0;
        if (blank >= hhfl_pkg::BLANK_DONE) begin
          blank    = hhfl_pkg::BLANK_DONE;
          hdr_seen = 1;
          hdr_pos  = pos;
        end
      end

      // pattern search, then value count up to the terminator
      if (phase == hhfl_pkg::PHASE_COUNT) begin
        if (b == term) phase = hhfl_pkg::PHASE_DONE;
        else if (found_len < CNT_MAX) found_len++;
      end else if (phase == hhfl_pkg::PHASE_SEARCH && n >= plen) begin
        eq = 1;
        for (p = 0; p < plen; p++)
          if (window[(plen - 1 - p) * 8 +: 8] != pattern[p * 8 +: 8]) eq = 0;
        if (eq && (!hdr_seen || n - plen < hdr_pos)) begin
          phase     = hhfl_pkg::PHASE_COUNT;
          found_off = n;
          found_len = 0;
        end
      end

      if (!last) return;

      // end of packet: one result word
      res.offset = '0;
      res.length = '0;
      if (n <= plen) begin
        eq = 1;
        for (p = 0; p < n; p++)
          if (to_lower(window[(n - 1 - p) * 8 +: 8]) != to_lower(pattern[p * 8 +: 8]))
            eq = 0;
        res.status = eq ? hhfl_pkg::STATUS_PARTIAL : hhfl_pkg::STATUS_NONE;
      end else if (phase == hhfl_pkg::PHASE_SEARCH) begin
        res.status = hhfl_pkg::STATUS_NONE;
      end else if (phase == hhfl_pkg::PHASE_COUNT) begin
        res.status = hhfl_pkg::STATUS_PARTIAL;
        res.offset = found_off[15:0];
      end else begin
        res.status = hhfl_pkg::STATUS_MATCH;
        res.offset = found_off[15:0];
        res.length = found_len[15:0];
      end
      results_due.push_back(res);
      clear_packet();
    endfunction

    function void check_result(logic [39:0] word);
      field_result_t want;
      if (results_due.size() == 0) begin
        $error("result word %h with no packet pending", word);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (word[1:0] != want.status) begin
        $error("status: expected %0d, got %0d", want.status, word[1:0]);
        errors++;
      end
      if (word[17:2] != want.offset) begin
        $error("value_offset: expected %0d, got %0d", want.offset, word[17:2]);
        errors++;
      end
      if (word[33:18] != want.length) begin
        $error("value_length: expected %0d, got %0d", want.length, word[33:18]);
        errors++;
      end
      if (word[39:34] != '0) begin
        $error("padding: expected 0, got %0d", word[39:34]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [7:0]  s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tready  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data  = '0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [39:0] m_tdata;
  wire         cfg_ready;

  locator_scoreboard board = new();
  logic [7:0] pkt[$];
  bit         tx_steady;
  bit         long_hold_req;
  int         bytes_sent;

  http_header_field_locator_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    logic [7:0] up;
    up = c & ~hhfl_pkg::CASE_OFFSET;
    return (up >= hhfl_pkg::CHAR_UPPER_A && up <= hhfl_pkg::CHAR_UPPER_Z) ?
           c ^ hhfl_pkg::CASE_OFFSET : c;
  endfunction

  function automatic logic [63:0] pack_text(string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[i * 8 +: 8] = s[i];
    return v;
  endfunction

  function automatic logic [7:0] text_byte();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
  endtask

  task automatic add_blank_line();
    pkt.push_back(hhfl_pkg::CHAR_CR);
    pkt.push_back(hhfl_pkg::CHAR_LF);
    pkt.push_back(hhfl_pkg::CHAR_CR);
    pkt.push_back(hhfl_pkg::CHAR_LF);
  endtask

  // Send the queued packet, last word marked, with random gaps unless tx_steady is set
  task automatic send_packet();
    int gap;
    bit last;
    foreach (pkt[i]) begin
      last = (i == pkt.size() - 1);
      s_tvalid <= 1'b1;
      s_tdata  <= pkt[i];
      s_tlast  <= last;
      do @(posedge clk); while (!s_tready);
      board.note_byte(pkt[i], last);
      bytes_sent++;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pkt.delete();
  endtask

  // Stop sending and wait for every result still due
  task automatic settle();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (board.results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers; unused bits of the data carry random values
  task automatic configure(logic [63:0] pat, logic [3:0] len, logic [7:0] term, bit stray);
    logic [63:0] vals[4];
    logic [1:0]  idxs[4];
    idxs = '{hhfl_pkg::CFG_PATTERN_BYTES, hhfl_pkg::CFG_PATTERN_LENGTH,
             hhfl_pkg::CFG_TERMINATOR, CFG_UNUSED};
    vals[0] = pat;
    vals[1] = {$urandom, $urandom};
    vals[1][3:0] = len;
    vals[2] = {$urandom, $urandom};
    vals[2][7:0] = term;
    vals[3] = {$urandom, $urandom};
    for (int i = 0; i < (stray ? 4 : 3); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      board.note_config(idxs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random packet: prefix-like short ones, noise, or a header line with the pattern
  task automatic build_packet(logic [63:0] pat, logic [3:0] len_reg, logic [7:0] term);
    int plen, kind, n, i;
    logic [7:0] c;
    plen = (len_reg == 0) ? 1 : (len_reg > 8) ? 8 : len_reg;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      n = $urandom_range(1, plen);
      for (i = 0; i < n; i++) begin
        c = pat[i * 8 +: 8];
        if ($urandom_range(0, 1)) c = flip_case(c);
        if ($urandom_range(0, 9) == 0) c = any_byte();
        pkt.push_back(c);
      end
    end else if (kind < 25) begin
      n = $urandom_range(1, 16);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0: pkt.push_back(hhfl_pkg::CHAR_CR);
          1: pkt.push_back(hhfl_pkg::CHAR_LF);
          default: pkt.push_back(any_byte());
        endcase
      end
    end else begin
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0) pkt.push_back(hhfl_pkg::CHAR_CR);
        else if ($urandom_range(0, 7) == 0) pkt.push_back(hhfl_pkg::CHAR_LF);
        else pkt.push_back(text_byte());
      end
      if ($urandom_range(0, 5) == 0) add_blank_line();
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, plen - 1) : plen;
      for (i = 0; i < plen; i++) begin
        c = pat[i * 8 +: 8];
        if (i == n) c = $urandom_range(0, 1) ? flip_case(c) : any_byte();
        pkt.push_back(c);
      end
      n = $urandom_range(0, 8);
      for (i = 0; i < n; i++) pkt.push_back(text_byte());
      if ($urandom_range(0, 3) != 0) pkt.push_back(term);
      n = $urandom_range(0, 4);
      for (i = 0; i < n; i++) pkt.push_back(text_byte());
      if ($urandom_range(0, 3) == 0) begin
        add_blank_line();
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) pkt.push_back(text_byte());
      end
    end
  endtask

  // Result side: random stalls, free-running stretches, one long hold on request
  initial begin
    int idle_left;
    int free_left;
    idle_left = 0;
    free_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      if (long_hold_req) begin
        long_hold_req = 0;
        idle_left = LONG_HOLD;
      end
      if (idle_left > 0) begin
        idle_left--;
        m_tready <= 1'b0;
      end else if (free_left > 0) begin
        free_left--;
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
        free_left = $urandom_range(50, 150);
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 20) begin
        idle_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        idle_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted word
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    int          phase_no, phase_start, i;
    logic [63:0] pat;
    logic [3:0]  len;
    logic [7:0]  term;
    phase_no = 0;
    tx_steady = 0;
    long_hold_req = 0;
    bytes_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset registers: six zero bytes, a single zero byte is a short prefix
    pkt.push_back(8'h00);
    send_packet();
    settle();

    // two-byte pattern, ';' ends the value
    configure(pack_text("ab"), 4'd2, ";", 1'b0);
    add_text("AB");                    // short packet, case folded
    send_packet();
    add_text("xab12;");                // match
    send_packet();
    add_text("abcd");                  // value runs to the end
    send_packet();
    pkt = '{8'hFF, 8'h00, 8'hFF, 8'h7F};
    send_packet();
    add_blank_line();                  // pattern after the header end
    add_text("ab;");
    send_packet();
    settle();

    // random phases, each with its own register setting
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      settle();
      case (phase_no % 6)
        0: len = 4'd1;
        1: len = 4'd8;
        2: len = 4'd0;
        3: len = 4'd15;
        default: len = 4'($urandom_range(0, 15));
      endcase
      for (i = 0; i < 8; i++)
        pat[i * 8 +: 8] = ($urandom_range(0, 4) == 0) ? any_byte()
                        : $urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                        : 8'($urandom_range("A", "Z"));
      if (phase_no % 6 == 4) pat = '1;
      if (phase_no % 6 == 5) pat = '0;
      case (phase_no % 6)
        0: term = 8'h00;
        1: term = 8'hFF;
        2, 3: term = hhfl_pkg::CHAR_CR;
        default: term = $urandom_range(0, 1) ? 8'(";") : any_byte();
      endcase
      configure(pat, len, term, phase_no % 6 == 2);
      tx_steady = ($urandom_range(0, 3) == 0);
      if (phase_no == 3) long_hold_req = 1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_packet(pat, len, term);
        send_packet();
      end
      phase_no++;
    end
    settle();

    if (board.errors == 0 && board.results_due.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
